// ===== rtl/kwlex_pkg.sv =====
// kwlex_pkg: shared types, token codes, scan modes and character constants
// for the keyword token lexer. No dependencies.
`timescale 1ns / 1ps

package kwlex_pkg;

	localparam int WORD_BUFFER_LEN_DEF = 6;
	localparam int OUTQ_DEPTH = 4;
	localparam int KW_COUNT = 8;
	localparam int KW_MAX_LEN = 6;

	// token kinds; keywords take codes 0..7 in KW_TEXT order
	localparam logic [4:0] TK_ASSIGN  = 5'd8;
	localparam logic [4:0] TK_EQUAL   = 5'd9;
	localparam logic [4:0] TK_LESS    = 5'd10;
	localparam logic [4:0] TK_PLUS    = 5'd11;
	localparam logic [4:0] TK_MINUS   = 5'd12;
	localparam logic [4:0] TK_TIMES   = 5'd13;
	localparam logic [4:0] TK_DIVIDE  = 5'd14;
	localparam logic [4:0] TK_LPAREN  = 5'd15;
	localparam logic [4:0] TK_RPAREN  = 5'd16;
	localparam logic [4:0] TK_SEMI    = 5'd17;
	localparam logic [4:0] TK_NUMBER  = 5'd18;
	localparam logic [4:0] TK_IDENT   = 5'd19;
	localparam logic [4:0] TK_ENDFILE = 5'd20;
	localparam logic [4:0] TK_ERROR   = 5'd21;

	// scan modes
	localparam logic [2:0] MODE_START   = 3'd0;
	localparam logic [2:0] MODE_COMMENT = 3'd1;
	localparam logic [2:0] MODE_NUMBER  = 3'd2;
	localparam logic [2:0] MODE_WORD    = 3'd3;
	localparam logic [2:0] MODE_COLON   = 3'd4;

	// characters
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_0      = 8'h30;
	localparam logic [7:0] CH_9      = 8'h39;
	localparam logic [7:0] CH_LA     = 8'h61;
	localparam logic [7:0] CH_LZ     = 8'h7A;
	localparam logic [7:0] CH_UA     = 8'h41;
	localparam logic [7:0] CH_UZ     = 8'h5A;

	// keyword text, unused tail bytes are zero and never compared
	localparam logic [7:0] KW_TEXT [KW_COUNT][KW_MAX_LEN] = '{
		'{8'h69, 8'h66, 8'h00, 8'h00, 8'h00, 8'h00},  // if
		'{8'h74, 8'h68, 8'h65, 8'h6E, 8'h00, 8'h00},  // then
		'{8'h65, 8'h6C, 8'h73, 8'h65, 8'h00, 8'h00},  // else
		'{8'h65, 8'h6E, 8'h64, 8'h00, 8'h00, 8'h00},  // end
		'{8'h72, 8'h65, 8'h70, 8'h65, 8'h61, 8'h74},  // repeat
		'{8'h75, 8'h6E, 8'h74, 8'h69, 8'h6C, 8'h00},  // until
		'{8'h72, 8'h65, 8'h61, 8'h64, 8'h00, 8'h00},  // read
		'{8'h77, 8'h72, 8'h69, 8'h74, 8'h65, 8'h00}   // write
	};
	localparam logic [2:0] KW_LEN [KW_COUNT] = '{
		3'd2, 3'd4, 3'd4, 3'd3, 3'd6, 3'd5, 3'd4, 3'd5
	};

	typedef struct packed {
		logic [4:0] kind;
		logic       last;
	} tok_t;

	// tokens produced by one transaction, cnt is 0..2
	typedef struct packed {
		logic [1:0] cnt;
		tok_t       tok0;
		tok_t       tok1;
	} push_t;

	typedef struct packed {
		logic       has;
		logic [4:0] kind;
		logic [2:0] mode;
		logic       word;
	} start_t;

	function automatic start_t scan_start(logic [7:0] c, logic eof);
		start_t r;
		r.has  = 1'b1;
		r.kind = TK_ERROR;
		r.mode = MODE_START;
		r.word = 1'b0;
		if (eof) begin
			r.kind = TK_ENDFILE;
		end else begin
			case (c) inside
				CH_SPACE, CH_TAB, CH_NL: r.has = 1'b0;
				CH_LBRACE: begin
					r.has  = 1'b0;
					r.mode = MODE_COMMENT;
				end
				[CH_0:CH_9]: begin
					r.has  = 1'b0;
					r.mode = MODE_NUMBER;
				end
				[CH_LA:CH_LZ], [CH_UA:CH_UZ]: begin
					r.has  = 1'b0;
					r.mode = MODE_WORD;
					r.word = 1'b1;
				end
				CH_COLON: begin
					r.has  = 1'b0;
					r.mode = MODE_COLON;
				end
				CH_PLUS:   r.kind = TK_PLUS;
				CH_MINUS:  r.kind = TK_MINUS;
				CH_STAR:   r.kind = TK_TIMES;
				CH_SLASH:  r.kind = TK_DIVIDE;
				CH_EQ:     r.kind = TK_EQUAL;
				CH_LT:     r.kind = TK_LESS;
				CH_LPAREN: r.kind = TK_LPAREN;
				CH_RPAREN: r.kind = TK_RPAREN;
				CH_SEMI:   r.kind = TK_SEMI;
				default:   r.kind = TK_ERROR;
			endcase
		end
		return r;
	endfunction

endpackage

// ===== rtl/kwlex_core.sv =====
// kwlex_core: scan mode, word buffer and per-character token decision.
// Depends on kwlex_pkg.
`timescale 1ns / 1ps

module kwlex_core #(
	parameter int WORD_BUFFER_LEN = kwlex_pkg::WORD_BUFFER_LEN_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [7:0]        char_code,
	input  logic              end_of_input,
	output kwlex_pkg::push_t  push
);

	localparam int LW = $clog2(WORD_BUFFER_LEN + 2);
	localparam int IW = $clog2(WORD_BUFFER_LEN);
	localparam logic [LW-1:0] LEN_MAX  = LW'(WORD_BUFFER_LEN);
	localparam logic [LW-1:0] LEN_LONG = LW'(WORD_BUFFER_LEN + 1);

	logic [2:0]    mode_q;
	logic [LW-1:0] len_q;
	logic [7:0]    chars_q [WORD_BUFFER_LEN];

	logic [2:0]    mode_n;
	logic [LW-1:0] len_n;
	logic          wr_en;
	logic [IW-1:0] wr_idx;
	logic          first_has;
	logic [4:0]    first_kind;
	logic          rescan;
	logic          is_digit;
	logic          is_letter;
	logic [4:0]    word_kind;
	logic          kw_hit;
	kwlex_pkg::start_t st0;
	kwlex_pkg::start_t st1;

	assign is_digit  = char_code inside {[kwlex_pkg::CH_0:kwlex_pkg::CH_9]};
	assign is_letter = char_code inside {[kwlex_pkg::CH_LA:kwlex_pkg::CH_LZ],
		[kwlex_pkg::CH_UA:kwlex_pkg::CH_UZ]};

	// keyword lookup over the first six kept letters
	always_comb begin
		logic hit;
		word_kind = kwlex_pkg::TK_IDENT;
		kw_hit    = 1'b0;
		for (int k = 0; k < kwlex_pkg::KW_COUNT; k++) begin
			hit = (len_q == LW'(kwlex_pkg::KW_LEN[k]));
			for (int i = 0; i < kwlex_pkg::KW_MAX_LEN; i++) begin
				if (i < int'(kwlex_pkg::KW_LEN[k]) && chars_q[i] != kwlex_pkg::KW_TEXT[k][i])
					hit = 1'b0;
			end
			if (hit && !kw_hit) begin
				word_kind = 5'(k);
				kw_hit    = 1'b1;
			end
		end
	end

	always_comb begin
		mode_n     = mode_q;
		len_n      = len_q;
		wr_en      = 1'b0;
		wr_idx     = '0;
		first_has  = 1'b0;
		first_kind = kwlex_pkg::TK_ERROR;
		rescan     = 1'b0;
		st0        = kwlex_pkg::scan_start(char_code, end_of_input);
		st1        = st0;
		case (mode_q)
			kwlex_pkg::MODE_COMMENT: begin
				if (end_of_input) begin
					first_has  = 1'b1;
					first_kind = kwlex_pkg::TK_ENDFILE;
					mode_n     = kwlex_pkg::MODE_START;
				end else if (char_code == kwlex_pkg::CH_RBRACE) begin
					mode_n = kwlex_pkg::MODE_START;
				end
			end
			kwlex_pkg::MODE_NUMBER: begin
				if (end_of_input || !is_digit) begin
					first_has  = 1'b1;
					first_kind = kwlex_pkg::TK_NUMBER;
					mode_n     = kwlex_pkg::MODE_START;
					rescan     = 1'b1;
				end
			end
			kwlex_pkg::MODE_WORD: begin
				if (!end_of_input && is_letter) begin
					if (len_q < LEN_MAX) begin
						wr_en  = 1'b1;
						wr_idx = len_q[IW-1:0];
						len_n  = len_q + LW'(1);
					end else begin
						len_n = LEN_LONG;
					end
				end else begin
					first_has  = 1'b1;
					first_kind = word_kind;
					len_n      = '0;
					mode_n     = kwlex_pkg::MODE_START;
					rescan     = 1'b1;
				end
			end
			kwlex_pkg::MODE_COLON: begin
				first_has = 1'b1;
				mode_n    = kwlex_pkg::MODE_START;
				if (!end_of_input && char_code == kwlex_pkg::CH_EQ) begin
					first_kind = kwlex_pkg::TK_ASSIGN;
				end else begin
					first_kind = kwlex_pkg::TK_ERROR;
					rescan     = 1'b1;
				end
			end
			default: begin
				// start mode, and any stray code recovers the same way
				first_has  = st0.has;
				first_kind = st0.kind;
				mode_n     = st0.mode;
				if (st0.word) begin
					wr_en  = 1'b1;
					wr_idx = '0;
					len_n  = LW'(1);
				end
			end
		endcase
		if (rescan) begin
			mode_n = st1.mode;
			if (st1.word) begin
				wr_en  = 1'b1;
				wr_idx = '0;
				len_n  = LW'(1);
			end
		end
	end

	always_comb begin
		push.cnt       = 2'd0;
		push.tok0.kind = first_kind;
		push.tok0.last = 1'b1;
		push.tok1.kind = st1.kind;
		push.tok1.last = 1'b1;
		if (accept && first_has) begin
			if (rescan && st1.has) begin
				push.cnt       = 2'd2;
				push.tok0.last = 1'b0;
			end else begin
				push.cnt = 2'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= kwlex_pkg::MODE_START;
			len_q  <= '0;
		end else if (accept) begin
			mode_q <= mode_n;
			len_q  <= len_n;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && wr_en)
			chars_q[wr_idx] <= char_code;
	end

	// word length is nonzero exactly while a word is being collected
	a_len_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q != kwlex_pkg::MODE_WORD) |-> (len_q == '0))
		else $error("word length left over outside a word");
	a_len_word: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == kwlex_pkg::MODE_WORD) |-> (len_q != '0 && len_q <= LEN_LONG))
		else $error("word length out of range inside a word");

endmodule

// ===== rtl/kwlex_outq.sv =====
// kwlex_outq: small token queue, takes up to two tokens per cycle and
// delivers one while out_stall is low. Depends on kwlex_pkg.
`timescale 1ns / 1ps

module kwlex_outq (
	input  logic             clk,
	input  logic             arst_n,
	input  kwlex_pkg::push_t push,
	output logic             full,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [4:0]       token_kind,
	output logic             last_token
);

	localparam int PW = $clog2(kwlex_pkg::OUTQ_DEPTH);
	localparam int CW = $clog2(kwlex_pkg::OUTQ_DEPTH + 1);

	kwlex_pkg::tok_t entry_q [kwlex_pkg::OUTQ_DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            pop;

	assign out_valid  = (count_q != '0);
	assign pop        = out_valid && !out_stall;
	assign token_kind = entry_q[rd_ptr_q].kind;
	assign last_token = entry_q[rd_ptr_q].last;
	// room for a full two-token transaction is required
	assign full       = (count_q > CW'(kwlex_pkg::OUTQ_DEPTH - 2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PW'(push.cnt);
			if (pop)
				rd_ptr_q <= rd_ptr_q + PW'(1);
			count_q <= count_q + CW'(push.cnt) - CW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0)
			entry_q[wr_ptr_q] <= push.tok0;
		if (push.cnt == 2'd2)
			entry_q[wr_ptr_q + PW'(1)] <= push.tok1;
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(kwlex_pkg::OUTQ_DEPTH))
		else $error("token queue overflow");
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		(push.cnt != 2'd0) |-> !full)
		else $error("tokens pushed without room");

endmodule

// ===== rtl/keyword_token_lexer.sv =====
// keyword_token_lexer: top level, scanner core plus output token queue.
// Depends on kwlex_pkg, kwlex_core, kwlex_outq.
`timescale 1ns / 1ps

// Takes one source byte (or an end-of-input mark) per transaction and
// returns token kinds, one per output transaction, last_token marking the
// final token a byte caused. A byte is taken every cycle while the
// four-entry token queue holds at most two tokens; the first token of a
// byte is offered the cycle after it is taken, unless older tokens wait.
// Unstalled output runs at one token per cycle, so a byte that yields two
// tokens (a number, word or lone colon ended by a byte that is a token
// itself, or by the end mark) needs an extra output transaction and can
// briefly stall steady input; words longer than the buffer stay identifiers.

module keyword_token_lexer #(
	parameter int WORD_BUFFER_LEN = kwlex_pkg::WORD_BUFFER_LEN_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] char_code,
	input  logic       end_of_input,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [4:0] token_kind,
	output logic       last_token
);

	logic             accept;
	logic             full;
	kwlex_pkg::push_t push;

	assign in_stall = full;
	assign accept   = in_valid && !full;

	kwlex_core #(
		.WORD_BUFFER_LEN(WORD_BUFFER_LEN)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.char_code    (char_code),
		.end_of_input (end_of_input),
		.push         (push)
	);

	kwlex_outq u_outq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.token_kind (token_kind),
		.last_token (last_token)
	);

endmodule

// ===== dv/keyword_token_lexer_tb.sv =====
// keyword_token_lexer_tb: self-checking bench for the keyword token lexer, a directed table
// then random lexeme streams, every token checked against its row's expectation or an in-bench scanner model.
// Depends on kwlex_pkg and keyword_token_lexer.
`timescale 1ns / 1ps

module keyword_token_lexer_tb;

	localparam int WORD_LEN = kwlex_pkg::WORD_BUFFER_LEN_DEF;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SEGMENT_ITEMS = 140;

	localparam logic [7:0] OP_CHARS [9] = '{kwlex_pkg::CH_PLUS, kwlex_pkg::CH_MINUS,
		kwlex_pkg::CH_STAR, kwlex_pkg::CH_SLASH, kwlex_pkg::CH_EQ, kwlex_pkg::CH_LT,
		kwlex_pkg::CH_LPAREN, kwlex_pkg::CH_RPAREN, kwlex_pkg::CH_SEMI};

	typedef struct packed {
		logic [7:0] ch;
		logic       eof;
		logic       typed;  // 1: tokens below are the expectation, else use the model
		logic [1:0] n;
		logic [4:0] k0;
		logic [4:0] k1;
	} stim_row_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] char_code = 8'h00;
	logic       end_of_input = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [4:0] token_kind;
	logic       last_token;

	keyword_token_lexer uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.char_code(char_code),
		.end_of_input(end_of_input),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.token_kind(token_kind),
		.last_token(last_token)
	);

	always #1 clk = ~clk;

	// scanner model state
	logic [2:0] lex_mode = kwlex_pkg::MODE_START;
	logic [7:0] lex_word [WORD_LEN];
	logic [2:0] lex_len = 3'd0;
	string kw_spelling [8] = '{"if", "then", "else", "end", "repeat", "until", "read", "write"};

	kwlex_pkg::tok_t pending_tokens [$];
	kwlex_pkg::tok_t expected_tok;
	stim_row_t directed_rows [25];
	int mismatch_count = 0;
	int cycle_count = 0;
	int counted_items = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	function automatic logic is_digit(logic [7:0] c);
		return c inside {[kwlex_pkg::CH_0:kwlex_pkg::CH_9]};
	endfunction

	function automatic logic is_letter(logic [7:0] c);
		return c inside {[kwlex_pkg::CH_LA:kwlex_pkg::CH_LZ],
			[kwlex_pkg::CH_UA:kwlex_pkg::CH_UZ]};
	endfunction

	function automatic logic is_blank(logic [7:0] c);
		return c inside {kwlex_pkg::CH_SPACE, kwlex_pkg::CH_TAB, kwlex_pkg::CH_NL};
	endfunction

	function automatic void keep_letter(logic [7:0] c);
		if (lex_len < WORD_LEN) begin
			lex_word[lex_len] = c;
			lex_len = lex_len + 3'd1;
		end else begin
			lex_len = 3'(WORD_LEN + 1);  // too long, can never be a keyword
		end
	endfunction

	// start-mode scan; -1 means no token
	function automatic int scan_from_start(logic [7:0] c, logic eof);
		if (eof)
			return int'(kwlex_pkg::TK_ENDFILE);
		if (is_blank(c))
			return -1;
		if (c == kwlex_pkg::CH_LBRACE) begin
			lex_mode = kwlex_pkg::MODE_COMMENT;
			return -1;
		end
		if (is_digit(c)) begin
			lex_mode = kwlex_pkg::MODE_NUMBER;
			return -1;
		end
		if (is_letter(c)) begin
			lex_len = 3'd0;
			keep_letter(c);
			lex_mode = kwlex_pkg::MODE_WORD;
			return -1;
		end
		if (c == kwlex_pkg::CH_COLON) begin
			lex_mode = kwlex_pkg::MODE_COLON;
			return -1;
		end
		case (c)
			kwlex_pkg::CH_PLUS:   return int'(kwlex_pkg::TK_PLUS);
			kwlex_pkg::CH_MINUS:  return int'(kwlex_pkg::TK_MINUS);
			kwlex_pkg::CH_STAR:   return int'(kwlex_pkg::TK_TIMES);
			kwlex_pkg::CH_SLASH:  return int'(kwlex_pkg::TK_DIVIDE);
			kwlex_pkg::CH_EQ:     return int'(kwlex_pkg::TK_EQUAL);
			kwlex_pkg::CH_LT:     return int'(kwlex_pkg::TK_LESS);
			kwlex_pkg::CH_LPAREN: return int'(kwlex_pkg::TK_LPAREN);
			kwlex_pkg::CH_RPAREN: return int'(kwlex_pkg::TK_RPAREN);
			kwlex_pkg::CH_SEMI:   return int'(kwlex_pkg::TK_SEMI);
			default:              return int'(kwlex_pkg::TK_ERROR);
		endcase
	endfunction

	function automatic void predict_tokens(input logic [7:0] c, input logic eof,
		output int first, output int second);
		logic rescan;
		logic hit;
		rescan = 1'b0;
		first = -1;
		second = -1;
		case (lex_mode)
			kwlex_pkg::MODE_COMMENT: begin
				if (eof) begin
					first = int'(kwlex_pkg::TK_ENDFILE);
					lex_mode = kwlex_pkg::MODE_START;
				end else if (c == kwlex_pkg::CH_RBRACE) begin
					lex_mode = kwlex_pkg::MODE_START;
				end
			end
			kwlex_pkg::MODE_NUMBER: begin
				if (eof || !is_digit(c)) begin
					first = int'(kwlex_pkg::TK_NUMBER);
					lex_mode = kwlex_pkg::MODE_START;
					rescan = 1'b1;
				end
			end
			kwlex_pkg::MODE_WORD: begin
				if (!eof && is_letter(c)) begin
					keep_letter(c);
				end else begin
					first = int'(kwlex_pkg::TK_IDENT);
					for (int k = 0; k < 8; k++) begin
						if (kw_spelling[k].len() == int'(lex_len)) begin
							hit = 1'b1;
							for (int i = 0; i < int'(lex_len); i++)
								if (lex_word[i] != kw_spelling[k][i])
									hit = 1'b0;
							if (hit)
								first = k;
						end
					end
					lex_len = 3'd0;
					lex_mode = kwlex_pkg::MODE_START;
					rescan = 1'b1;
				end
			end
			kwlex_pkg::MODE_COLON: begin
				lex_mode = kwlex_pkg::MODE_START;
				if (!eof && c == kwlex_pkg::CH_EQ) begin
					first = int'(kwlex_pkg::TK_ASSIGN);
				end else begin
					first = int'(kwlex_pkg::TK_ERROR);
					rescan = 1'b1;
				end
			end
			default: begin
				lex_mode = kwlex_pkg::MODE_START;
				first = scan_from_start(c, eof);
			end
		endcase
		if (rescan)
			second = scan_from_start(c, eof);
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		mismatch_count++;
		$display("MISMATCH at cycle %0d: %s got %0d expected %0d", cycle_count, what, got,
			want);
	endtask

	// drive one transaction, wait for it to be taken, then queue its tokens
	task automatic send_char(input logic [7:0] c, input logic eof, input logic typed,
		input logic [1:0] n, input logic [4:0] k0, input logic [4:0] k1);
		int first;
		int second;
		kwlex_pkg::tok_t t;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		char_code <= c;
		end_of_input <= eof;
		do @(posedge clk); while (in_stall);
		counted_items++;
		predict_tokens(c, eof, first, second);
		if (typed) begin
			first = (n > 2'd0) ? int'(k0) : -1;
			second = (n > 2'd1) ? int'(k1) : -1;
		end
		if (first >= 0) begin
			t.kind = 5'(first);
			t.last = (second < 0);
			pending_tokens = {pending_tokens, t};
		end
		if (second >= 0) begin
			t.kind = 5'(second);
			t.last = 1'b1;
			pending_tokens = {pending_tokens, t};
		end
	endtask

	task automatic send_byte(input logic [7:0] c);
		send_char(c, 1'b0, 1'b0, 2'd0, 5'd0, 5'd0);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	function automatic logic [7:0] rand_letter();
		if ($urandom_range(1))
			return 8'(kwlex_pkg::CH_LA + $urandom_range(25));
		return 8'(kwlex_pkg::CH_UA + $urandom_range(25));
	endfunction

	// one lexeme of random content, mostly well formed, some noise
	task automatic gen_lexeme();
		int roll;
		int len;
		string s;
		logic [7:0] b;
		roll = $urandom_range(99);
		if (roll < 20) begin
			s = kw_spelling[$urandom_range(7)];
			if ($urandom_range(7) == 0)
				s.putc(0, s[0] - 8'd32);  // keywords are case-sensitive
			send_text(s);
		end else if (roll < 35) begin
			len = ($urandom_range(4) == 0) ? $urandom_range(12, 7) : $urandom_range(4, 1);
			for (int i = 0; i < len; i++)
				send_byte(rand_letter());
		end else if (roll < 40) begin
			// keyword with extra letters, including past the buffer length
			send_text(kw_spelling[$urandom_range(7)]);
			len = $urandom_range(4, 1);
			for (int i = 0; i < len; i++)
				send_byte(8'(kwlex_pkg::CH_LA + $urandom_range(25)));
		end else if (roll < 55) begin
			len = $urandom_range(4, 1);
			for (int i = 0; i < len; i++)
				send_byte(8'(kwlex_pkg::CH_0 + $urandom_range(9)));
		end else if (roll < 70) begin
			send_byte(OP_CHARS[$urandom_range(8)]);
		end else if (roll < 75) begin
			send_byte(kwlex_pkg::CH_COLON);
			send_byte(kwlex_pkg::CH_EQ);
		end else if (roll < 78) begin
			send_byte(kwlex_pkg::CH_COLON);
		end else if (roll < 83) begin
			send_byte(kwlex_pkg::CH_LBRACE);
			len = $urandom_range(5);
			for (int i = 0; i < len; i++) begin
				b = 8'($urandom_range(255));
				send_byte((b == kwlex_pkg::CH_RBRACE) ? kwlex_pkg::CH_SPACE : b);
			end
			if ($urandom_range(3) == 0)
				send_char(8'($urandom_range(255)), 1'b1, 1'b0, 2'd0, 5'd0, 5'd0);
			else
				send_byte(kwlex_pkg::CH_RBRACE);
		end else if (roll < 88) begin
			send_char(8'($urandom_range(255)), 1'b1, 1'b0, 2'd0, 5'd0, 5'd0);
		end else begin
			send_byte(8'($urandom_range(255)));
		end
		// no separator half the time, so the next lexeme ends this one
		if ($urandom_range(1)) begin
			case ($urandom_range(2))
				0: send_byte(kwlex_pkg::CH_SPACE);
				1: send_byte(kwlex_pkg::CH_TAB);
				default: send_byte(kwlex_pkg::CH_NL);
			endcase
		end
	endtask

	// hold input off until every queued token has come out
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_tokens.size() != 0);
	endtask

	always @(posedge clk)
		out_stall <= ($urandom_range(99) < recv_stall_pct);

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_tokens.size() == 0) begin
				report_mismatch("unexpected token, kind", int'(token_kind), -1);
			end else begin
				expected_tok = pending_tokens.pop_front();
				if (token_kind !== expected_tok.kind)
					report_mismatch("token_kind", int'(token_kind), int'(expected_tok.kind));
				if (last_token !== expected_tok.last)
					report_mismatch("last_token", int'(last_token), int'(expected_tok.last));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("keyword_token_lexer test failed");
			$finish;
		end
	end

	initial begin
		directed_rows = '{
			'{8'h00, 1'b1, 1'b1, 2'd1, kwlex_pkg::TK_ENDFILE, 5'd0},
			'{8'h00, 1'b0, 1'b1, 2'd1, kwlex_pkg::TK_ERROR, 5'd0},
			'{8'hFF, 1'b0, 1'b1, 2'd1, kwlex_pkg::TK_ERROR, 5'd0},
			'{kwlex_pkg::CH_PLUS, 1'b0, 1'b1, 2'd1, kwlex_pkg::TK_PLUS, 5'd0},
			'{kwlex_pkg::CH_MINUS, 1'b0, 1'b1, 2'd1, kwlex_pkg::TK_MINUS, 5'd0},
			'{kwlex_pkg::CH_STAR, 1'b0, 1'b1, 2'd1, kwlex_pkg::TK_TIMES, 5'd0},
			'{kwlex_pkg::CH_SLASH, 1'b0, 1'b1, 2'd1, kwlex_pkg::TK_DIVIDE, 5'd0},
			'{kwlex_pkg::CH_EQ, 1'b0, 1'b1, 2'd1, kwlex_pkg::TK_EQUAL, 5'd0},
			'{kwlex_pkg::CH_LT, 1'b0, 1'b1, 2'd1, kwlex_pkg::TK_LESS, 5'd0},
			'{kwlex_pkg::CH_LPAREN, 1'b0, 1'b1, 2'd1, kwlex_pkg::TK_LPAREN, 5'd0},
			'{kwlex_pkg::CH_RPAREN, 1'b0, 1'b1, 2'd1, kwlex_pkg::TK_RPAREN, 5'd0},
			'{kwlex_pkg::CH_SEMI, 1'b0, 1'b1, 2'd1, kwlex_pkg::TK_SEMI, 5'd0},
			'{kwlex_pkg::CH_COLON, 1'b0, 1'b1, 2'd0, 5'd0, 5'd0},
			'{kwlex_pkg::CH_EQ, 1'b0, 1'b1, 2'd1, kwlex_pkg::TK_ASSIGN, 5'd0},
			'{kwlex_pkg::CH_COLON, 1'b0, 1'b1, 2'd0, 5'd0, 5'd0},
			'{kwlex_pkg::CH_SEMI, 1'b0, 1'b1, 2'd2, kwlex_pkg::TK_ERROR, kwlex_pkg::TK_SEMI},
			'{kwlex_pkg::CH_LBRACE, 1'b0, 1'b1, 2'd0, 5'd0, 5'd0},
			'{8'h61, 1'b0, 1'b1, 2'd0, 5'd0, 5'd0},
			'{8'hFF, 1'b1, 1'b1, 2'd1, kwlex_pkg::TK_ENDFILE, 5'd0},
			'{8'h69, 1'b0, 1'b0, 2'd0, 5'd0, 5'd0},
			'{8'h66, 1'b0, 1'b0, 2'd0, 5'd0, 5'd0},
			'{8'h37, 1'b0, 1'b0, 2'd0, 5'd0, 5'd0},
			'{8'h00, 1'b1, 1'b0, 2'd0, 5'd0, 5'd0},
			'{8'h78, 1'b0, 1'b0, 2'd0, 5'd0, 5'd0},
			'{8'h7F, 1'b1, 1'b0, 2'd0, 5'd0, 5'd0}
		};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed_rows[i])
			send_char(directed_rows[i].ch, directed_rows[i].eof, directed_rows[i].typed,
				directed_rows[i].n, directed_rows[i].k0, directed_rows[i].k1);
		for (int seg = 0; seg < 8; seg++) begin
			wait_drained();
			case (seg % 4)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 53;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 53;
				end
				default: begin
					send_idle_pct = 22;
					recv_stall_pct = 22;
				end
			endcase
			counted_items = 0;
			while (counted_items < SEGMENT_ITEMS)
				gen_lexeme();
		end
		wait_drained();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0)
			$display("keyword_token_lexer test passed");
		else
			$display("keyword_token_lexer test failed");
		$finish;
	end

endmodule
